// ----- rtl/pts_pkg.sv -----
// Package for the priority thread scheduler: op, kind and status codes and beat structs.
// No dependencies.
package pts_pkg;
	localparam logic [2:0] OP_TICK  = 3'd0;
	localparam logic [2:0] OP_SCHED = 3'd1;
	localparam logic [2:0] OP_ADD   = 3'd2;
	localparam logic [2:0] OP_KILL  = 3'd3;
	localparam logic [2:0] OP_SLEEP = 3'd4;
	localparam logic [2:0] OP_BLOCK = 3'd5;
	localparam logic [2:0] OP_EVENT = 3'd6;

	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_EVENT  = 2'd1;
	localparam logic [1:0] KIND_CHOSEN = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_THR_LIMIT = 3'd1;
	localparam logic [2:0] ST_LAST      = 3'd2;
	localparam logic [2:0] ST_NO_THREAD = 3'd3;
	localparam logic [2:0] ST_EV_LIMIT  = 3'd4;
	localparam logic [2:0] ST_NONE_RDY  = 3'd5;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  prio;
		logic [31:0] target_id;
		logic [2:0]  slot_sel;
		logic        block_flag;
		logic [31:0] duration;
		logic [31:0] event_period;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  status;
		logic [2:0]  chosen_slot;
		logic [31:0] chosen_id;
		logic [2:0]  event_index;
		logic        switch_req;
		logic        last;
	} out_beat_t;
endpackage

// ----- rtl/priority_thread_scheduler.sv -----
// Priority thread scheduler top level: slot ring, periodic event table, scan sequencer.
// Depends on pts_pkg.
//
// One command beat is taken at a time, and in_ready stays low until its last result beat is
// loaded. A tick walks event_count entries of the event table and then every slot, one entry
// a cycle, the event walk only while the output register is free. Schedule walks the live
// ring one slot a cycle; add and kill search the whole slot table. Other commands go
// straight to execution. Each result beat waits in the single output register until taken,
// and any load of that register stalls while full.
module priority_thread_scheduler #(
	parameter int MAX_SLOTS  = 8,
	parameter int MAX_EVENTS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pts_pkg::in_beat_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pts_pkg::out_beat_t   out_data
);
	import pts_pkg::*;

	localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
	localparam int EW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
	localparam int SC = $clog2(MAX_SLOTS + 1);
	localparam int EC = $clog2(MAX_EVENTS + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVSC  = 3'd1;
	localparam logic [2:0] S_SLSC  = 3'd2;
	localparam logic [2:0] S_RING  = 3'd3;
	localparam logic [2:0] S_FIND  = 3'd4;
	localparam logic [2:0] S_EXEC  = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;

	logic [2:0]  state_q;
	in_beat_t    cmd_q;
	logic [31:0] now_q;
	logic [SW-1:0] run_q;
	logic [SC-1:0] live_q;
	logic [15:0] idc_q;
	logic [EC-1:0] evc_q;
	logic [MAX_SLOTS-1:0] alive_q, asleep_q, blk_q;
	logic [7:0]  prio_q [MAX_SLOTS];
	logic [31:0] wake_q [MAX_SLOTS];
	logic [SW-1:0] nxt_q [MAX_SLOTS];
	logic [SW-1:0] prv_q [MAX_SLOTS];
	logic [31:0] sid_q [MAX_SLOTS];
	logic [31:0] per_q [MAX_EVENTS];
	logic [31:0] due_q [MAX_EVENTS];

	logic [SC-1:0] cnt_q;
	logic [SW-1:0] cur_q;
	logic [EW-1:0] eidx_q;
	logic          found_q;
	logic [SW-1:0] best_q;
	logic [7:0]    bestp_q;
	out_beat_t     out_q;
	logic          ov_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign out_data  = out_q;

	wire [31:0] rsum = due_q[eidx_q] + 32'd0;
	wire        ev_hit = (rsum == now_q);
	wire        rdy_cur = alive_q[cur_q] && !asleep_q[cur_q] && !blk_q[cur_q];
	wire [SW-1:0] cur_inc = (cur_q == SW'(MAX_SLOTS - 1)) ? '0 : cur_q + 1'b1;
	wire [EW-1:0] ev_inc = eidx_q + 1'b1;
	wire        ev_end = ({{(32-EW){1'b0}}, eidx_q} + 32'd1 >= {{(32-EC){1'b0}}, evc_q})
		|| (32'(eidx_q) == MAX_EVENTS - 1);
	wire        sl_end = (cur_q == SW'(MAX_SLOTS - 1));
	wire        out_free = !ov_q || out_ready;
	wire        ov_set = out_free && ((state_q == S_EVSC && ev_hit) || state_q == S_OUT);

	function automatic out_beat_t beat(logic [1:0] kd, logic [2:0] st, logic [2:0] sl,
			logic [31:0] id, logic [2:0] ev, logic sw, logic lst);
		out_beat_t r;
		r.kind = kd;
		r.status = st;
		r.chosen_slot = sl;
		r.chosen_id = id;
		r.event_index = ev;
		r.switch_req = sw;
		r.last = lst;
		return r;
	endfunction

	function automatic out_beat_t rep(logic [2:0] st, logic sw);
		return beat(KIND_STATUS, st, 3'd0, 32'd0, 3'd0, sw, 1'b1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			now_q    <= '0;
			run_q    <= '0;
			live_q   <= '0;
			idc_q    <= '0;
			evc_q    <= '0;
			alive_q  <= '0;
			asleep_q <= '0;
			blk_q    <= '0;
			ov_q     <= 1'b0;
			for (int i = 0; i < MAX_SLOTS; i++) wake_q[i] <= '0;
		end else begin
			if (ov_set) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q <= in_data;
						cur_q <= '0;
						eidx_q <= '0;
						cnt_q <= '0;
						found_q <= 1'b0;
						case (in_data.op)
							OP_TICK: begin
								now_q <= now_q + 32'd1;
								state_q <= (evc_q != '0) ? S_EVSC : S_SLSC;
							end
							OP_SCHED: begin
								cur_q <= nxt_q[run_q];
								state_q <= (live_q == '0) ? S_EXEC : S_RING;
							end
							OP_ADD, OP_KILL: state_q <= S_FIND;
							default: state_q <= S_EXEC;
						endcase
					end
				end
				S_EVSC: begin
					if (out_free) begin
						if (ev_hit) begin
							due_q[eidx_q] <= per_q[eidx_q] + now_q;
							out_q <= beat(KIND_EVENT, ST_OK, 3'd0, 32'd0, 3'(eidx_q), 1'b0, 1'b0);
						end
						eidx_q <= ev_inc;
						if (ev_end) state_q <= S_SLSC;
					end
				end
				S_SLSC: begin
					if (alive_q[cur_q] && asleep_q[cur_q] && wake_q[cur_q] == now_q) begin
						asleep_q[cur_q] <= 1'b0;
						wake_q[cur_q] <= '0;
					end
					cur_q <= cur_inc;
					if (sl_end) state_q <= S_EXEC;
				end
				S_RING: begin
					if (rdy_cur && (!found_q || prio_q[cur_q] < bestp_q)) begin
						found_q <= 1'b1;
						best_q <= cur_q;
						bestp_q <= prio_q[cur_q];
					end
					cur_q <= nxt_q[cur_q];
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q + 1'b1 >= live_q) state_q <= S_EXEC;
				end
				S_FIND: begin
					if (!found_q && (cmd_q.op == OP_ADD ? !alive_q[cur_q]
						: (alive_q[cur_q] && sid_q[cur_q] == cmd_q.target_id))) begin
						found_q <= 1'b1;
						best_q <= cur_q;
					end
					cur_q <= cur_inc;
					if (sl_end) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (out_free) begin
						state_q <= S_OUT;
						case (cmd_q.op)
							OP_TICK: out_q <= rep(ST_OK, 1'b1);
							OP_SCHED: begin
								if (live_q == '0 || !found_q) out_q <= rep(ST_NONE_RDY, 1'b0);
								else begin
									run_q <= best_q;
									out_q <= beat(KIND_CHOSEN, ST_OK, 3'(best_q), sid_q[best_q],
										3'd0, best_q != run_q, 1'b1);
								end
							end
							OP_ADD: begin
								if (!found_q) out_q <= rep(ST_THR_LIMIT, 1'b0);
								else begin
									alive_q[best_q] <= 1'b1;
									prio_q[best_q] <= cmd_q.prio;
									sid_q[best_q] <= {idc_q, 16'(best_q)};
									idc_q <= idc_q + 16'd1;
									asleep_q[best_q] <= 1'b0;
									wake_q[best_q] <= '0;
									blk_q[best_q] <= 1'b0;
									if (live_q == '0) begin
										nxt_q[best_q] <= best_q;
										prv_q[best_q] <= best_q;
										run_q <= best_q;
									end else begin
										prv_q[best_q] <= run_q;
										nxt_q[best_q] <= nxt_q[run_q];
										nxt_q[run_q] <= best_q;
										prv_q[nxt_q[run_q]] <= best_q;
									end
									live_q <= live_q + 1'b1;
									out_q <= beat(KIND_STATUS, ST_OK, 3'(best_q),
										{idc_q, 16'(best_q)}, 3'd0, 1'b0, 1'b1);
								end
							end
							OP_KILL: begin
								if (live_q == SC'(1)) out_q <= rep(ST_LAST, 1'b0);
								else if (!found_q) out_q <= rep(ST_NO_THREAD, 1'b0);
								else begin
									alive_q[best_q] <= 1'b0;
									prv_q[nxt_q[best_q]] <= prv_q[best_q];
									nxt_q[prv_q[best_q]] <= nxt_q[best_q];
									live_q <= live_q - 1'b1;
									if (best_q == run_q) run_q <= prv_q[best_q];
									out_q <= rep(ST_OK, best_q == run_q);
								end
							end
							OP_SLEEP: begin
								if (live_q == '0 || !alive_q[run_q])
									out_q <= rep(ST_NO_THREAD, 1'b0);
								else begin
									wake_q[run_q] <= cmd_q.duration + now_q;
									asleep_q[run_q] <= 1'b1;
									out_q <= rep(ST_OK, 1'b1);
								end
							end
							OP_BLOCK: begin
								if (32'(cmd_q.slot_sel) >= MAX_SLOTS)
									out_q <= rep(ST_NO_THREAD, 1'b0);
								else begin
									blk_q[SW'(cmd_q.slot_sel)] <= cmd_q.block_flag;
									out_q <= rep(ST_OK, 1'b0);
								end
							end
							OP_EVENT: begin
								if (32'(evc_q) >= MAX_EVENTS) out_q <= rep(ST_EV_LIMIT, 1'b0);
								else begin
									per_q[EW'(evc_q)] <= cmd_q.event_period;
									due_q[EW'(evc_q)] <= now_q + cmd_q.event_period
										+ {{(32-EC){1'b0}}, evc_q};
									evc_q <= evc_q + 1'b1;
									out_q <= beat(KIND_STATUS, ST_OK, 3'd0, 32'd0, 3'(evc_q),
										1'b0, 1'b1);
								end
							end
							default: out_q <= rep(ST_OK, 1'b0);
						endcase
					end
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted beat while busy");
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		32'(live_q) == $countones(alive_q))
		else $error("live count mismatch");
endmodule

// ----- tb/pts_checker.sv -----
// Scoreboard for the priority thread scheduler: watches both channels, predicts the
// result beats of every accepted command and compares them in order. Depends on pts_pkg.
`timescale 1ns / 100ps
module pts_checker #(
	parameter int SLOTS  = 8,
	parameter int EVENTS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  pts_pkg::in_beat_t  in_data,
	input  logic               out_valid,
	input  logic               out_ready,
	input  pts_pkg::out_beat_t out_data,
	output int                 errors,
	output int                 pending,
	output int                 beats_checked
);
	import pts_pkg::*;

	out_beat_t exp_q[$];

	logic [31:0] now_ticks;
	logic [2:0]  run_slot;
	logic [3:0]  live_cnt;
	logic [15:0] id_cnt;
	logic [3:0]  ev_cnt;
	logic        alive[SLOTS];
	logic        asleep[SLOTS];
	logic        blocked[SLOTS];
	logic [7:0]  prio[SLOTS];
	logic [31:0] wake_at[SLOTS];
	logic [2:0]  nxt[SLOTS];
	logic [2:0]  prv[SLOTS];
	logic [31:0] tid[SLOTS];
	logic [31:0] ev_period[EVENTS];
	logic [31:0] ev_due[EVENTS];

	function automatic out_beat_t mk(logic [1:0] kind, logic [2:0] status, logic [2:0] slot,
			logic [31:0] id, logic [2:0] ev, logic sw, logic lst);
		out_beat_t b;
		b.kind = kind;
		b.status = status;
		b.chosen_slot = slot;
		b.chosen_id = id;
		b.event_index = ev;
		b.switch_req = sw;
		b.last = lst;
		return b;
	endfunction

	task automatic reply(logic [2:0] status, logic sw);
		exp_q.push_back(mk(KIND_STATUS, status, 3'd0, 32'd0, 3'd0, sw, 1'b1));
	endtask

	function automatic bit is_ready(int s);
		return alive[s] && !asleep[s] && !blocked[s];
	endfunction

	task automatic predict_command(in_beat_t c);
		int best;
		int k;
		int s;
		logic [7:0] bestp;
		logic [2:0] old;
		logic [2:0] pv;
		logic [2:0] nx;
		best = -1;
		k = -1;
		bestp = '0;
		case (c.op)
			OP_TICK: begin
				now_ticks = now_ticks + 32'd1;
				for (int i = 0; i < ev_cnt && i < EVENTS; i++) begin
					if (ev_due[i] == now_ticks) begin
						ev_due[i] = ev_period[i] + now_ticks;
						exp_q.push_back(mk(KIND_EVENT, ST_OK, 3'd0, 32'd0, 3'(i), 1'b0, 1'b0));
					end
				end
				for (int i = 0; i < SLOTS; i++) begin
					if (alive[i] && asleep[i] && wake_at[i] == now_ticks) begin
						asleep[i] = 1'b0;
						wake_at[i] = '0;
					end
				end
				reply(ST_OK, 1'b1);
			end
			OP_SCHED: begin
				if (live_cnt == 0) begin
					reply(ST_NONE_RDY, 1'b0);
				end else begin
					old = run_slot;
					s = nxt[run_slot];
					for (int i = 0; i < live_cnt && i < SLOTS; i++) begin
						if (is_ready(s) && (best < 0 || prio[s] < bestp)) begin
							best = s;
							bestp = prio[s];
						end
						s = nxt[s];
					end
					if (best < 0) begin
						reply(ST_NONE_RDY, 1'b0);
					end else begin
						run_slot = 3'(best);
						exp_q.push_back(mk(KIND_CHOSEN, ST_OK, 3'(best), tid[best], 3'd0,
							3'(best) != old, 1'b1));
					end
				end
			end
			OP_ADD: begin
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!alive[i]) k = i;
				if (k < 0) begin
					reply(ST_THR_LIMIT, 1'b0);
				end else begin
					alive[k] = 1'b1;
					prio[k] = c.prio;
					tid[k] = {id_cnt, 16'(k)};
					id_cnt = id_cnt + 16'd1;
					asleep[k] = 1'b0;
					wake_at[k] = '0;
					blocked[k] = 1'b0;
					if (live_cnt == 0) begin
						nxt[k] = 3'(k);
						prv[k] = 3'(k);
						run_slot = 3'(k);
					end else begin
						nx = nxt[run_slot];
						prv[k] = run_slot;
						nxt[k] = nx;
						nxt[run_slot] = 3'(k);
						prv[nx] = 3'(k);
					end
					live_cnt = live_cnt + 4'd1;
					exp_q.push_back(mk(KIND_STATUS, ST_OK, 3'(k), tid[k], 3'd0, 1'b0, 1'b1));
				end
			end
			OP_KILL: begin
				if (live_cnt == 1) begin
					reply(ST_LAST, 1'b0);
				end else begin
					for (int i = SLOTS - 1; i >= 0; i--)
						if (alive[i] && tid[i] == c.target_id) k = i;
					if (k < 0) begin
						reply(ST_NO_THREAD, 1'b0);
					end else begin
						pv = prv[k];
						nx = nxt[k];
						alive[k] = 1'b0;
						prv[nx] = pv;
						nxt[pv] = nx;
						live_cnt = live_cnt - 4'd1;
						if (3'(k) == run_slot) begin
							run_slot = pv;
							reply(ST_OK, 1'b1);
						end else begin
							reply(ST_OK, 1'b0);
						end
					end
				end
			end
			OP_SLEEP: begin
				if (live_cnt == 0 || !alive[run_slot]) begin
					reply(ST_NO_THREAD, 1'b0);
				end else begin
					wake_at[run_slot] = c.duration + now_ticks;
					asleep[run_slot] = 1'b1;
					reply(ST_OK, 1'b1);
				end
			end
			OP_BLOCK: begin
				blocked[c.slot_sel] = c.block_flag;
				reply(ST_OK, 1'b0);
			end
			OP_EVENT: begin
				if (ev_cnt >= EVENTS) begin
					reply(ST_EV_LIMIT, 1'b0);
				end else begin
					ev_period[ev_cnt] = c.event_period;
					ev_due[ev_cnt] = now_ticks + c.event_period + 32'(ev_cnt);
					exp_q.push_back(mk(KIND_STATUS, ST_OK, 3'd0, 32'd0, 3'(ev_cnt), 1'b0, 1'b1));
					ev_cnt = ev_cnt + 4'd1;
				end
			end
			default: reply(ST_OK, 1'b0);
		endcase
	endtask

	task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_beat_t e;
		if (!arst_n) begin
			exp_q.delete();
			errors = 0;
			beats_checked = 0;
			now_ticks = '0;
			run_slot = '0;
			live_cnt = '0;
			id_cnt = '0;
			ev_cnt = '0;
			for (int i = 0; i < SLOTS; i++) begin
				alive[i] = 1'b0;
				asleep[i] = 1'b0;
				blocked[i] = 1'b0;
				wake_at[i] = '0;
			end
		end else begin
			if (out_valid && out_ready) begin
				if (exp_q.size() == 0) begin
					$error("result beat with nothing expected: %h", out_data);
					errors++;
				end else begin
					e = exp_q.pop_front();
					cmp("kind", 32'(e.kind), 32'(out_data.kind));
					cmp("status", 32'(e.status), 32'(out_data.status));
					cmp("chosen_slot", 32'(e.chosen_slot), 32'(out_data.chosen_slot));
					cmp("chosen_id", e.chosen_id, out_data.chosen_id);
					cmp("event_index", 32'(e.event_index), 32'(out_data.event_index));
					cmp("switch_req", 32'(e.switch_req), 32'(out_data.switch_req));
					cmp("last", 32'(e.last), 32'(out_data.last));
					beats_checked++;
				end
			end
			if (in_valid && in_ready)
				predict_command(in_data);
		end
		pending = exp_q.size();
	end
endmodule

// ----- tb/tb_priority_thread_scheduler.sv -----
// Testbench top for the priority thread scheduler: clock, reset, command stimulus and
// result back-pressure; checking is done by pts_checker. Depends on pts_pkg and the RTL.
`timescale 1ns / 100ps
module tb_priority_thread_scheduler;
	import pts_pkg::*;

	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam int RANDOM_CMDS = 250;
	localparam int CYCLE_LIMIT = 1000000;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_data;
	int        errors;
	int        pending;
	int        beats_checked;
	int        cycles;
	int        sent;
	bit        hold_out;
	logic [31:0] known_ids[$];

	priority_thread_scheduler u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	pts_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.errors(errors), .pending(pending), .beats_checked(beats_checked)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("priority_thread_scheduler regression: fail");
			$finish;
		end
	end

	// remember thread ids the block hands out so kills can hit live threads
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready && out_data.kind != KIND_EVENT &&
				(out_data.kind == KIND_CHOSEN || out_data.chosen_id != 0 ||
				out_data.chosen_slot != 0)) begin
			if (known_ids.size() >= 32)
				void'(known_ids.pop_front());
			known_ids.push_back(out_data.chosen_id);
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: runs of ready, short and occasional long stalls, one very long hold
	initial begin
		int n;
		bit held;
		held = 1'b0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_out && !held) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				held = 1'b1;
			end
			n = $urandom_range(1, 30);
			out_ready <= 1'b1;
			repeat (n) @(posedge clk);
			n = gap_len();
			if (n > 0) begin
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send(in_beat_t b);
		int g;
		in_data <= b;
		in_valid <= 1'b1;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		sent++;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		@(posedge clk);
	endtask

	function automatic in_beat_t cmd(logic [2:0] op);
		in_beat_t b;
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		b = raw[$bits(in_beat_t)-1:0];
		b.op = op;
		return b;
	endfunction

	function automatic in_beat_t random_cmd();
		in_beat_t b;
		int r;
		r = $urandom_range(0, 99);
		if (r < 28)
			b = cmd(OP_TICK);
		else if (r < 48)
			b = cmd(OP_SCHED);
		else if (r < 62)
			b = cmd(OP_ADD);
		else if (r < 73)
			b = cmd(OP_KILL);
		else if (r < 83)
			b = cmd(OP_SLEEP);
		else if (r < 93)
			b = cmd(OP_BLOCK);
		else if (r < 97)
			b = cmd(OP_EVENT);
		else
			b = cmd(OP_UNUSED);
		if (b.op == OP_KILL && known_ids.size() > 0 && $urandom_range(0, 3) != 0)
			b.target_id = known_ids[$urandom_range(0, known_ids.size() - 1)];
		if ($urandom_range(0, 9) < 7)
			b.duration = $urandom_range(0, 6);
		if ($urandom_range(0, 9) < 7)
			b.event_period = $urandom_range(1, 12);
		if (b.op == OP_BLOCK && $urandom_range(0, 2) != 0)
			b.block_flag = 1'b0;
		return b;
	endfunction

	initial begin
		in_beat_t b;
		sent = 0;
		hold_out = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty scheduler
		send(cmd(OP_TICK));
		send(cmd(OP_SCHED));
		send(cmd(OP_SLEEP));
		b = cmd(OP_KILL);
		b.target_id = 32'd0;
		send(b);
		// single thread, lowest urgency, cannot be killed
		b = cmd(OP_ADD);
		b.prio = 8'd255;
		send(b);
		b = cmd(OP_KILL);
		b.target_id = 32'd0;
		send(b);
		send(cmd(OP_SCHED));
		b = cmd(OP_SLEEP);
		b.duration = 32'd0;
		send(b);
		send(cmd(OP_SCHED));
		b = cmd(OP_ADD);
		b.prio = 8'd0;
		send(b);
		b = cmd(OP_BLOCK);
		b.slot_sel = 3'd1;
		b.block_flag = 1'b1;
		send(b);
		send(cmd(OP_SCHED));
		b.block_flag = 1'b0;
		send(b);
		b = cmd(OP_BLOCK);
		b.slot_sel = 3'd7;
		b.block_flag = 1'b1;
		send(b);
		send(cmd(OP_SCHED));
		// kill the running thread, then an unknown id
		b = cmd(OP_KILL);
		b.target_id = 32'h0001_0001;
		send(b);
		b.target_id = 32'hDEAD_BEEF;
		send(b);
		b = cmd(OP_EVENT);
		b.event_period = 32'd1;
		send(b);
		b.event_period = 32'd0;
		send(b);
		b.event_period = 32'hFFFF_FFFF;
		send(b);
		repeat (3) send(cmd(OP_TICK));
		b = '1;
		send(b);
		// fill the slot table past its limit
		repeat (8) send(cmd(OP_ADD));
		send(cmd(OP_SCHED));
		wait_drained();

		for (int i = 0; i < RANDOM_CMDS; i++) begin
			if (i == 60)
				hold_out = 1'b1;
			if (i == 150)
				wait_drained();
			send(random_cmd());
		end
		wait_drained();
		repeat (40) @(posedge clk);

		$display("commands sent: %0d, result beats checked: %0d, cycles: %0d",
			sent, beats_checked, cycles);
		$display("ops tick/schedule/add/kill/sleep/block/event/unused, tables filled past limit");
		if (errors == 0 && pending == 0)
			$display("priority_thread_scheduler regression: pass");
		else
			$display("priority_thread_scheduler regression: fail");
		$finish;
	end
endmodule

// ----- sim.f -----
rtl/pts_pkg.sv
rtl/priority_thread_scheduler.sv
tb/pts_checker.sv
tb/tb_priority_thread_scheduler.sv
